// ===== hw/rtl/ssid_pkg.sv =====
// Shared constants and types for the sorted set insert/delete block.
// No dependencies; imported by sorted_set_insert_delete.
package ssid_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;
  localparam int S_TDATA_W    = 32;
  localparam int M_TDATA_W    = 40;

  // Operation carried in s_tuser.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result kind carried in m_tuser.
  localparam logic KIND_LIST   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_SEARCH     = 8'b0000_0010,
    ST_DECIDE     = 8'b0000_0100,
    ST_SHIFT_UP   = 8'b0000_1000,
    ST_PLACE      = 8'b0001_0000,
    ST_SHIFT_DOWN = 8'b0010_0000,
    ST_LIST       = 8'b0100_0000,
    ST_STATUS     = 8'b1000_0000
  } ssid_state_t;

endpackage

// ===== hw/rtl/sorted_set_insert_delete.sv =====
// Sorted set of distinct signed 32-bit values kept in one synchronous memory.
// Depends on ssid_pkg.
// A delete scans to the matching entry at p, then moves the later entries down one place. An
// insert scans to the insert point p, then shifts the tail up and places the value (or appends
// it at the end); the stored entries are then listed, with the new one when it was added.
// Throughput is one item at a time; each step is set by the single memory read port, which
// moves one entry per cycle, and listed beats leave at one per cycle while m_tready is high.
// Reset (rst, synchronous, active high) empties the set; the memory itself is not cleared,
// as only entries below the count are ever read.
module sorted_set_insert_delete
  import ssid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] item_value
  input  logic                 s_tuser,   // [0] opcode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] listed_value, [32] success,
                                          // [33] store_full, [39:34] zero
  output logic                 m_tuser,   // [0] result_kind
  output logic                 m_tlast    // last_of_run
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // The value store: one write port and one registered read port.
  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data;

  ssid_state_t state;
  logic [CW-1:0] count;
  logic [IW-1:0] sp;        // scan pointer, the next address to read
  logic          sp_end;    // the scan has issued its final read
  logic          rv;        // rd_data holds the entry at rd_idx
  logic [IW-1:0] rd_idx;
  logic          op;
  logic signed [DATA_W-1:0] val;
  logic [CW-1:0] pos;       // first position whose value is not below val
  logic          present;
  logic          full;
  logic          success;

  logic signed [DATA_W-1:0] out_value;
  logic          out_success;
  logic          out_full;

  logic          re;
  logic          we;
  logic [IW-1:0] wa;
  logic signed [DATA_W-1:0] wd;
  logic [IW-1:0] sp_lim;
  logic          hit;
  logic          scan_last;
  logic          out_free;
  logic          load_out;
  logic [CW-1:0] count_m1;

  assign s_tready  = (state == ST_IDLE);
  assign count_m1  = count - CW'(1);
  assign scan_last = ({1'b0, rd_idx} == {1'b0, count_m1[IW-1:0]}) && (count != '0);
  assign hit       = rv && (rd_data >= val);
  assign out_free  = !m_tvalid || m_tready;
  assign load_out  = (state == ST_LIST) && rv && out_free;

  assign m_tdata = {{(M_TDATA_W - DATA_W - 2){1'b0}}, out_full, out_success, out_value};

  // Read issue and write selection for the current phase.
  always_comb begin
    re     = 1'b0;
    we     = 1'b0;
    wa     = rd_idx;
    wd     = rd_data;
    sp_lim = count_m1[IW-1:0];
    case (state)
      ST_SEARCH: begin
        re = !sp_end && !hit;
      end
      ST_DECIDE: begin
        // Append at the end: no entries need to move.
        we = (op == OP_INSERT) && !present && (count != CAP_C) && (pos == count);
        wa = pos[IW-1:0];
        wd = val;
      end
      ST_SHIFT_UP: begin
        re     = !sp_end;
        sp_lim = pos[IW-1:0];
        we     = rv;
        wa     = rd_idx + IW'(1);
      end
      ST_PLACE: begin
        we = 1'b1;
        wa = pos[IW-1:0];
        wd = val;
      end
      ST_SHIFT_DOWN: begin
        re = !sp_end;
        we = rv;
        wa = rd_idx - IW'(1);
      end
      ST_LIST: begin
        re = !sp_end && (!rv || out_free);
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[sp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      sp_end   <= 1'b1;
      rv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Read bookkeeping; in the list phase a read waits while the output stalls.
      rv <= re || (rv && (state == ST_LIST) && !out_free);
      if (re) begin
        rd_idx <= sp;
        if (sp == sp_lim) begin
          sp_end <= 1'b1;
        end else if (state == ST_SHIFT_UP) begin
          sp <= sp - IW'(1);
        end else begin
          sp <= sp + IW'(1);
        end
      end

      // Output register.
      if (load_out) begin
        m_tvalid    <= 1'b1;
        m_tuser     <= KIND_LIST;
        out_value   <= rd_data;
        out_success <= 1'b0;
        out_full    <= full;
        m_tlast     <= scan_last;
      end else if ((state == ST_STATUS) && out_free) begin
        m_tvalid    <= 1'b1;
        m_tuser     <= KIND_STATUS;
        out_value   <= '0;
        out_success <= success;
        out_full    <= 1'b0;
        m_tlast     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op   <= s_tuser;
            val  <= s_tdata;
            full <= 1'b0;
            if (count == '0) begin
              if (s_tuser == OP_INSERT) begin
                pos     <= '0;
                present <= 1'b0;
                state   <= ST_DECIDE;
              end else begin
                success <= 1'b0;
                state   <= ST_STATUS;
              end
            end else begin
              sp     <= '0;
              sp_end <= 1'b0;
              state  <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            pos     <= CW'(rd_idx);
            present <= (rd_data == val);
            state   <= ST_DECIDE;
          end else if (rv && scan_last) begin
            pos     <= count;
            present <= 1'b0;
            state   <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (op == OP_INSERT) begin
            if (present) begin
              sp     <= '0;
              sp_end <= 1'b0;
              state  <= ST_LIST;
            end else if (count == CAP_C) begin
              full   <= 1'b1;
              sp     <= '0;
              sp_end <= 1'b0;
              state  <= ST_LIST;
            end else if (pos == count) begin
              count  <= count + CW'(1);
              sp     <= '0;
              sp_end <= 1'b0;
              state  <= ST_LIST;
            end else begin
              // Move the tail up one place, from the top entry downwards.
              sp     <= count_m1[IW-1:0];
              sp_end <= 1'b0;
              state  <= ST_SHIFT_UP;
            end
          end else begin
            if (!present) begin
              success <= 1'b0;
              state   <= ST_STATUS;
            end else if (pos == count_m1) begin
              count   <= count_m1;
              success <= 1'b1;
              state   <= ST_STATUS;
            end else begin
              // Close the gap, moving each later entry down one place.
              sp     <= IW'(pos + CW'(1));
              sp_end <= 1'b0;
              state  <= ST_SHIFT_DOWN;
            end
          end
        end
        ST_SHIFT_UP: begin
          if (rv && (rd_idx == pos[IW-1:0])) begin
            state <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          count  <= count + CW'(1);
          sp     <= '0;
          sp_end <= 1'b0;
          state  <= ST_LIST;
        end
        ST_SHIFT_DOWN: begin
          if (rv && scan_last) begin
            count   <= count_m1;
            success <= 1'b1;
            state   <= ST_STATUS;
          end
        end
        ST_LIST: begin
          if (load_out && scan_last) begin
            state <= ST_IDLE;
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("entry count above capacity");

  // A write never lands on the entry being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (wa != sp))
    else $error("read and write of the same entry in one cycle");

  // Listed entries always lie inside the stored range.
  a_list_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIST && rv) |-> ({1'b0, rd_idx} < count))
    else $error("list read beyond the stored entries");

  // A status beat is always the last of its run.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_STATUS) |-> m_tlast)
    else $error("status beat without last mark");

endmodule
